FILE: src/wshi_pkg.sv
package wshi_pkg;

   // command codes
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_ORDER     = 3'd2;
   localparam logic [2:0] ST_DUPLICATE = 3'd3;
   localparam logic [2:0] ST_CLAMPED   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   // configuration register indexes
   localparam logic REG_WINDOW  = 1'b0;
   localparam logic REG_LOGGING = 1'b1;

   localparam logic [31:0] WINDOW_RESET = 32'd1000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_NEWEST,
      ST_PUSH_CHECK,
      ST_EVICT_RD,
      ST_EVICT_CHECK,
      ST_Q_RD_ENDS,
      ST_Q_CHECK_FIRST,
      ST_Q_CHECK_LAST,
      ST_S_RD,
      ST_S_CHECK,
      ST_I_RD,
      ST_I_WAIT,
      ST_DIVIDE,
      ST_MULT,
      ST_ROUND,
      ST_DONE
   } fsm_type;

endpackage

FILE: src/wshi_divider.sv
// restoring divider: quotient = floor((dt << 31) / span), one bit a cycle
module wshi_divider
   import wshi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dt,
   input  logic [31:0] span,
   output logic        done,
   output logic [31:0] quotient
);

   logic [32:0] rem_ff, rem_in;
   logic [62:0] num_ff, num_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [33:0] trial;

   assign trial = {rem_ff, num_ff[62]} - {2'b00, span};

   // one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         num_in  = {dt, 31'd0};
         quo_in  = '0;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
         end else begin
            rem_in = {rem_ff[31:0], num_ff[62]};
         end
         quo_in = {quo_ff[30:0], !trial[33]};
         num_in = {num_ff[61:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd62) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = busy_ff && (cnt_ff == 6'd62);
   assign quotient = quo_in;

endmodule

FILE: src/windowed_sample_history_interp_unit.sv
// Windowed sample history with linear interpolation.
// req_ channel: one beat per command (push or query). tdata holds, from the
// lowest bit up, command, sample_time, sample_value. rsp_ channel returns one
// beat per request: result_value, status, entry_count.
// The samples sit in a synchronous ring memory of DEPTH entries, one read
// port and one write port, with registered read data.
// A push into a non-empty ring first reads the newest entry to reject an
// out-of-order or duplicate time; an accepted push is written, and outside
// logging mode entries beyond the window are then evicted from the oldest end
// one at a time. A query on an empty ring goes straight to the response;
// otherwise it checks the oldest and then the newest end for a clamped result,
// and one inside the span runs a binary search (up to log2 of held count
// levels, 8 at most), reads the bracketing pair and does a serial division.
// The block handles one request at a time; the next is taken in the cycle
// after the previous response beat has been taken.
// While rsp_tready is low the response holds and no new request starts.
// Reset (synchronous, active high) empties the ring at once: the held
// count and oldest pointer clear, memory contents need no clearing pass.
// Configuration writes are not held back: one made mid-request can affect it.
module windowed_sample_history_interp_unit
   import wshi_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // command, sample_time, sample_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // result_value, status, entry_count
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // ring memories
   logic [31:0] time_mem  [DEPTH];
   logic [31:0] value_mem [DEPTH];
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [31:0]   wr_time, wr_value, rd_time, rd_value;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr]  <= wr_time;
         value_mem[wr_addr] <= wr_value;
      end
      rd_time  <= time_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
   end

   // state
   fsm_type state_ff, state_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] window_ff;
   logic        logging_ff;
   logic        cmd_ff, cmd_in;
   logic [31:0] t_ff, t_in, v_ff, v_in;
   logic [2:0]  status_ff, status_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid;
   logic [31:0] tlo_ff, tlo_in, vlo_ff, vlo_in, thi_ff, thi_in, vhi_ff, vhi_in;
   logic [31:0] res_ff, res_in;
   logic [63:0] prod_ff, prod_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_res_ff, out_res_in;
   logic [2:0]  out_st_ff, out_st_in;
   logic [CW-1:0] out_cnt_ff, out_cnt_in;
   logic        div_start, div_done;
   logic [31:0] weight;
   logic [32:0] diff, mag;
   logic [31:0] q;

   // logical index to ring slot
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] lg);
      logic [CW:0] s;
      s = {{(CW-AW+1){1'b0}}, base} + {1'b0, lg};
      if (s >= (CW+1)'(DEPTH)) begin
         s = s - (CW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         logging_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WINDOW:  window_ff  <= csr_wdata;
            REG_LOGGING: logging_ff <= csr_wdata[0];
            default:     ;
         endcase
      end
   end

   wshi_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dt      (t_ff - tlo_ff),
      .span    (thi_ff - tlo_ff),
      .done    (div_done),
      .quotient(weight)
   );

   assign diff = {vhi_ff[31], vhi_ff} - {vlo_ff[31], vlo_ff};
   assign mag  = diff[32] ? (~diff + 33'd1) : diff;
   assign q    = 32'((prod_ff + 64'h4000_0000) >> 31);
   assign mid  = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign req_tready = (state_ff == ST_IDLE) && !out_valid_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      oldest_in = oldest_ff;
      count_in  = count_ff;
      cmd_in    = cmd_ff;
      t_in      = t_ff;
      v_in      = v_ff;
      status_in = status_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      tlo_in    = tlo_ff;
      vlo_in    = vlo_ff;
      thi_in    = thi_ff;
      vhi_in    = vhi_ff;
      res_in    = res_ff;
      prod_in   = prod_ff;
      rd_addr   = oldest_ff;
      wr_en     = 1'b0;
      wr_addr   = oldest_ff;
      wr_time   = t_ff;
      wr_value  = v_ff;
      div_start = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_res_in   = out_res_ff;
      out_st_in    = out_st_ff;
      out_cnt_in   = out_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in    = req_tdata[0];
               t_in      = req_tdata[32:1];
               v_in      = req_tdata[64:33];
               status_in = ST_OK;
               res_in    = '0;
               if (req_tdata[0] == CMD_PUSH) begin
                  if (count_ff == '0) begin
                     state_in = ST_PUSH_CHECK;
                  end else begin
                     state_in = ST_RD_NEWEST;
                  end
               end else if (count_ff == '0) begin
                  status_in = ST_EMPTY;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_Q_RD_ENDS;
               end
            end
         end
         ST_RD_NEWEST: begin
            rd_addr  = slot_of(oldest_ff, count_ff - CW'(1));
            state_in = ST_PUSH_CHECK;
         end
         ST_PUSH_CHECK: begin
            if (count_ff != '0 && t_ff < rd_time) begin
               status_in = ST_ORDER;
               state_in  = ST_DONE;
            end else if (count_ff != '0 && t_ff == rd_time) begin
               status_in = ST_DUPLICATE;
               state_in  = ST_DONE;
            end else begin
               wr_en = 1'b1;
               if (count_ff == CW'(DEPTH)) begin
                  wr_addr   = oldest_ff;
                  oldest_in = slot_of(oldest_ff, CW'(1));
                  status_in = ST_FULL;
               end else begin
                  wr_addr  = slot_of(oldest_ff, count_ff);
                  count_in = count_ff + CW'(1);
               end
               state_in = logging_ff ? ST_DONE : ST_EVICT_RD;
            end
         end
         ST_EVICT_RD: begin
            rd_addr  = oldest_ff;
            state_in = (count_ff > CW'(1)) ? ST_EVICT_CHECK : ST_DONE;
         end
         ST_EVICT_CHECK: begin
            if (t_ff - rd_time > window_ff) begin
               oldest_in = slot_of(oldest_ff, CW'(1));
               count_in  = count_ff - CW'(1);
               state_in  = ST_EVICT_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_Q_RD_ENDS: begin
            rd_addr  = oldest_ff;
            state_in = ST_Q_CHECK_FIRST;
         end
         ST_Q_CHECK_FIRST: begin
            rd_addr = slot_of(oldest_ff, count_ff - CW'(1));
            if (t_ff <= rd_time) begin
               res_in    = rd_value;
               status_in = (t_ff == rd_time) ? ST_OK : ST_CLAMPED;
               state_in  = ST_DONE;
            end else begin
               tlo_in   = rd_time;
               vlo_in   = rd_value;
               state_in = ST_Q_CHECK_LAST;
            end
         end
         ST_Q_CHECK_LAST: begin
            if (t_ff >= rd_time) begin
               res_in    = rd_value;
               status_in = (t_ff == rd_time) ? ST_OK : ST_CLAMPED;
               state_in  = ST_DONE;
            end else begin
               thi_in   = rd_time;
               vhi_in   = rd_value;
               lo_in    = '0;
               hi_in    = count_ff - CW'(1);
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: begin
            if (hi_ff - lo_ff > CW'(1)) begin
               rd_addr  = slot_of(oldest_ff, mid);
               state_in = ST_S_CHECK;
            end else begin
               rd_addr  = slot_of(oldest_ff, lo_ff);
               state_in = ST_I_RD;
            end
         end
         ST_S_CHECK: begin
            if (rd_time <= t_ff) begin
               lo_in = mid;
            end else begin
               hi_in = mid;
            end
            state_in = ST_S_RD;
         end
         ST_I_RD: begin
            tlo_in   = rd_time;
            vlo_in   = rd_value;
            rd_addr  = slot_of(oldest_ff, hi_ff);
            state_in = ST_I_WAIT;
         end
         ST_I_WAIT: begin
            thi_in   = rd_time;
            vhi_in   = rd_value;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // span is never zero inside the held range
            div_start = 1'b1;
            state_in  = ST_MULT;
         end
         ST_MULT: begin
            if (div_done) begin
               prod_in  = 64'(mag) * 64'(weight);
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            res_in   = diff[32] ? (vlo_ff - q) : (vlo_ff + q);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               out_res_in   = (cmd_ff == CMD_PUSH) ? 32'd0 : res_ff;
               out_st_in    = status_ff;
               out_cnt_in   = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff     <= cmd_in;
      t_ff       <= t_in;
      v_ff       <= v_in;
      status_ff  <= status_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      tlo_ff     <= tlo_in;
      vlo_ff     <= vlo_in;
      thi_ff     <= thi_in;
      vhi_ff     <= vhi_in;
      res_ff     <= res_in;
      prod_ff    <= prod_in;
      out_res_ff <= out_res_in;
      out_st_ff  <= out_st_in;
      out_cnt_ff <= out_cnt_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(13-CW){1'b0}}, out_cnt_ff, out_st_ff, out_res_ff};

endmodule
